/* hdl/lacbu_pkg.sv */
// Shared types, constants and cell rule functions for the aging Life byte update.
package lacbu_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CELL_W  = 2;
  localparam int unsigned CELLS   = BYTE_W / CELL_W;
  localparam int unsigned ROW_W   = CELLS + 2;
  localparam int unsigned COUNT_W = 4;

  localparam logic [CELL_W-1:0]  AGE_DEAD = 2'd0;
  localparam logic [CELL_W-1:0]  AGE_BORN = 2'd1;
  localparam logic [CELL_W-1:0]  AGE_MAX  = 2'd3;
  localparam logic [COUNT_W-1:0] CNT_TWO  = 4'd2;
  localparam logic [COUNT_W-1:0] CNT_THREE = 4'd3;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [CELL_W-1:0]  age_t;
  typedef logic [CELLS-1:0]   mask_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [COUNT_W-1:0] count_t;

  // The nine bytes of one neighborhood, as one item.
  typedef struct packed {
    byte_t above_left;
    byte_t above_mid;
    byte_t above_right;
    byte_t left_byte;
    byte_t center_byte;
    byte_t right_byte;
    byte_t below_left;
    byte_t below_mid;
    byte_t below_right;
  } nbhd_t;

  // Live flag per cell of a packed byte.
  function automatic mask_t live_bits(input byte_t b);
    mask_t r;
    for (int i = 0; i < CELLS; i++) begin
      r[i] = |b[CELL_W*i +: CELL_W];
    end
    return r;
  endfunction

  // Six-bit live row: the right cell of the left byte, four middle cells,
  // the left cell of the right byte.
  function automatic row_t live_row(input byte_t l, input byte_t m, input byte_t r);
    mask_t ll;
    mask_t mm;
    mask_t rr;
    ll = live_bits(l);
    mm = live_bits(m);
    rr = live_bits(r);
    return {rr[0], mm, ll[CELLS-1]};
  endfunction

  // B3/S23 with saturating age.
  function automatic age_t next_age(input age_t age, input count_t n);
    age_t nage;
    nage = AGE_DEAD;
    if (age != AGE_DEAD) begin
      if (n == CNT_TWO || n == CNT_THREE) begin
        nage = (age == AGE_MAX) ? AGE_MAX : age + AGE_BORN;
      end
    end else if (n == CNT_THREE) begin
      nage = AGE_BORN;
    end
    return nage;
  endfunction

endpackage

/* hdl/lacbu_next_gen.sv */
// Combinational next-generation logic for one packed byte and its change mask.
module lacbu_next_gen
  import lacbu_pkg::*;
(
  input  nbhd_t nbhd,
  output byte_t next_byte,
  output mask_t change_mask
);

  row_t up;
  row_t mid;
  row_t dn;

  assign up  = live_row(nbhd.above_left, nbhd.above_mid, nbhd.above_right);
  assign mid = live_row(nbhd.left_byte, nbhd.center_byte, nbhd.right_byte);
  assign dn  = live_row(nbhd.below_left, nbhd.below_mid, nbhd.below_right);

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    count_t n;
    age_t   age;
    age_t   nage;

    assign n = count_t'(up[i]) + count_t'(up[i+1]) + count_t'(up[i+2])
             + count_t'(dn[i]) + count_t'(dn[i+1]) + count_t'(dn[i+2])
             + count_t'(mid[i]) + count_t'(mid[i+2]);
    assign age  = nbhd.center_byte[CELL_W*i +: CELL_W];
    assign nage = next_age(age, n);
    assign next_byte[CELL_W*i +: CELL_W] = nage;
    assign change_mask[i] = (nage != age);
  end

endmodule

/* hdl/life_aging_cell_byte_update.sv */
// Top level: input register, next-generation logic and result register.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_stall, in_<nine neighborhood bytes>
//   out     | output    | out_valid, out_stall, out_next_byte, out_change_mask
//
// One item is accepted per cycle while in_stall is low; its result passes through
// the input register, then the result register, with the cell rule between them.
// Reset clears both valid flags; payload registers are not reset.
// A stall on the result side holds the result register and backs up into the
// input register; in_stall rises only when both stages are full and blocked.
module life_aging_cell_byte_update
  import lacbu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  byte_t in_above_left,
  input  byte_t in_above_mid,
  input  byte_t in_above_right,
  input  byte_t in_left_byte,
  input  byte_t in_center_byte,
  input  byte_t in_right_byte,
  input  byte_t in_below_left,
  input  byte_t in_below_mid,
  input  byte_t in_below_right,
  output logic  out_valid,
  input  logic  out_stall,
  output byte_t out_next_byte,
  output mask_t out_change_mask
);

  logic  in_vld_r;
  nbhd_t nbhd_r;
  logic  out_vld_r;
  byte_t next_byte_r;
  mask_t change_mask_r;
  byte_t next_byte_nxt;
  mask_t change_mask_nxt;
  logic  out_load;
  logic  in_load;

  assign out_load = !out_vld_r || !out_stall;
  assign in_load  = !in_vld_r || out_load;
  assign in_stall = !in_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_load) begin
        in_vld_r <= in_valid;
      end
      if (out_load) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      nbhd_r <= '{above_left:  in_above_left,
                  above_mid:   in_above_mid,
                  above_right: in_above_right,
                  left_byte:   in_left_byte,
                  center_byte: in_center_byte,
                  right_byte:  in_right_byte,
                  below_left:  in_below_left,
                  below_mid:   in_below_mid,
                  below_right: in_below_right};
    end
    if (out_load && in_vld_r) begin
      next_byte_r   <= next_byte_nxt;
      change_mask_r <= change_mask_nxt;
    end
  end

  lacbu_next_gen u_next_gen (
    .nbhd        (nbhd_r),
    .next_byte   (next_byte_nxt),
    .change_mask (change_mask_nxt)
  );

  assign out_valid       = out_vld_r;
  assign out_next_byte   = next_byte_r;
  assign out_change_mask = change_mask_r;

endmodule

/* tb/sv/life_aging_cell_byte_update_test.sv */
// Self-checking testbench for the aging Life byte update with random neighborhoods and stalls.
`timescale 1ns / 100ps

module life_aging_cell_byte_update_test;
  import lacbu_pkg::*;

  localparam int STUCK_LIMIT = 500;
  localparam int RANDOM_HOODS = 2000;

  typedef struct {
    nbhd_t hood;
    int    gap;
    bit    drain;
  } hood_item_t;

  typedef struct {
    byte_t next_byte;
    mask_t change_mask;
  } gen_t;

  logic  clk;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  nbhd_t in_hood = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  byte_t out_next_byte;
  mask_t out_change_mask;

  hood_item_t hood_queue[$];
  gen_t       next_gen_q[$];
  hood_item_t staged;
  bit         have_staged = 1'b0;
  int         idle_left = 0;
  int         sender_calm = 0;
  int         receiver_calm = 0;
  int         hold_left = 0;
  logic       in_taken = 1'b0;
  logic       out_taken = 1'b0;
  int         mismatches = 0;
  int         stuck = 0;

  life_aging_cell_byte_update u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_above_left   (in_hood.above_left),
    .in_above_mid    (in_hood.above_mid),
    .in_above_right  (in_hood.above_right),
    .in_left_byte    (in_hood.left_byte),
    .in_center_byte  (in_hood.center_byte),
    .in_right_byte   (in_hood.right_byte),
    .in_below_left   (in_hood.below_left),
    .in_below_mid    (in_hood.below_mid),
    .in_below_right  (in_hood.below_right),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_byte   (out_next_byte),
    .out_change_mask (out_change_mask)
  );

  // Live flags of one neighborhood row, from the near cell of the left byte to the
  // near cell of the right byte.
  function automatic logic [5:0] live_span(byte_t l, byte_t m, byte_t r);
    logic [5:0] s;
    s[0] = |l[7:6];
    for (int i = 0; i < 4; i++) begin
      s[i+1] = |m[2*i +: 2];
    end
    s[5] = |r[1:0];
    return s;
  endfunction

  function automatic gen_t life_next_gen(nbhd_t h);
    logic [5:0] up;
    logic [5:0] mid;
    logic [5:0] dn;
    age_t       age;
    age_t       nage;
    int         count;
    gen_t       g;
    up  = live_span(h.above_left, h.above_mid, h.above_right);
    mid = live_span(h.left_byte, h.center_byte, h.right_byte);
    dn  = live_span(h.below_left, h.below_mid, h.below_right);
    g.next_byte = '0;
    g.change_mask = '0;
    for (int i = 0; i < 4; i++) begin
      count = int'(up[i]) + int'(up[i+1]) + int'(up[i+2])
            + int'(dn[i]) + int'(dn[i+1]) + int'(dn[i+2])
            + int'(mid[i]) + int'(mid[i+2]);
      age = h.center_byte[2*i +: 2];
      if (age != AGE_DEAD) begin
        if (count == 2 || count == 3) begin
          nage = (age == AGE_MAX) ? AGE_MAX : age + AGE_BORN;
        end else begin
          nage = AGE_DEAD;
        end
      end else begin
        nage = (count == 3) ? AGE_BORN : AGE_DEAD;
      end
      g.next_byte[2*i +: 2] = nage;
      g.change_mask[i] = (nage != age);
    end
    return g;
  endfunction

  function automatic byte_t seeded_byte(int pct);
    byte_t b;
    b = '0;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 99) < pct) begin
        b[2*i +: 2] = 2'($urandom_range(1, 3));
      end
    end
    return b;
  endfunction

  task automatic queue_hood(nbhd_t h, bit drain);
    hood_item_t it;
    it.hood = h;
    it.drain = drain;
    if (sender_calm > 0) begin
      sender_calm--;
      it.gap = 0;
    end else begin
      it.gap = $urandom_range(0, 5);
      if ($urandom_range(0, 30) == 0) begin
        sender_calm = $urandom_range(20, 60);
      end
    end
    hood_queue.push_back(it);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: presents one item at a time, holding it until accepted.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (!have_staged && hood_queue.size() > 0) begin
        staged = hood_queue.pop_front();
        have_staged = 1'b1;
        idle_left = staged.gap;
      end
      if (have_staged && idle_left == 0 && !(staged.drain && next_gen_q.size() != 0)) begin
        in_hood <= staged.hood;
        in_valid <= 1'b1;
        have_staged = 1'b0;
      end else begin
        in_valid <= 1'b0;
        if (have_staged && idle_left > 0) begin
          idle_left--;
        end
      end
    end
  end

  // Receiver: draws a stall length for each result.
  always @(negedge clk) begin
    if (out_taken) begin
      if (receiver_calm > 0) begin
        receiver_calm--;
        hold_left = 0;
      end else begin
        hold_left = $urandom_range(0, 5);
        if ($urandom_range(0, 30) == 0) begin
          receiver_calm = $urandom_range(20, 60);
        end
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    gen_t want;
    in_taken <= (rst_n === 1'b1) && in_valid && !in_stall;
    out_taken <= (rst_n === 1'b1) && out_valid && !out_stall;
    if (rst_n === 1'b1) begin
      if (in_valid && !in_stall) begin
        next_gen_q.push_back(life_next_gen(in_hood));
      end
      if (out_valid && !out_stall) begin
        if (next_gen_q.size() == 0) begin
          $error("result with no item outstanding: next_byte %h change_mask %h",
                 out_next_byte, out_change_mask);
          mismatches++;
        end else begin
          want = next_gen_q.pop_front();
          if (out_next_byte !== want.next_byte) begin
            $error("next_byte mismatch: expected %h, actual %h", want.next_byte, out_next_byte);
            mismatches++;
          end
          if (out_change_mask !== want.change_mask) begin
            $error("change_mask mismatch: expected %h, actual %h",
                   want.change_mask, out_change_mask);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && !(in_valid && !in_stall) && !(out_valid && !out_stall)) begin
      stuck <= stuck + 1;
    end else begin
      stuck <= 0;
    end
    if (stuck == STUCK_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    nbhd_t h;
    int    mode;
    int    pct;

    h = '0;
    queue_hood(h, 1'b0);
    h = '1;
    queue_hood(h, 1'b0);
    h = '0;
    h.center_byte = 8'hFF;
    queue_hood(h, 1'b0);
    h.center_byte = 8'h55;
    queue_hood(h, 1'b0);
    h.center_byte = 8'hAA;
    queue_hood(h, 1'b0);
    h = '0;
    h.above_mid = 8'h15;
    queue_hood(h, 1'b0);
    // Only the far cells of the side bytes are set, so they must not count.
    h = '0;
    h.above_left = 8'h3F;
    h.left_byte = 8'h3F;
    h.below_left = 8'h3F;
    h.above_right = 8'hFC;
    h.right_byte = 8'hFC;
    h.below_right = 8'hFC;
    h.center_byte = 8'h41;
    queue_hood(h, 1'b0);
    h = '0;
    h.above_left = 8'h80;
    h.left_byte = 8'hC0;
    h.below_left = 8'h40;
    queue_hood(h, 1'b0);
    h = '0;
    h.above_right = 8'h01;
    h.right_byte = 8'h03;
    h.below_right = 8'h02;
    queue_hood(h, 1'b0);
    h = '0;
    h.above_mid = 8'h04;
    h.center_byte = 8'h0C;
    h.below_mid = 8'h08;
    queue_hood(h, 1'b0);
    h = '0;
    h.above_mid = 8'h1B;
    h.center_byte = 8'hE4;
    h.below_mid = 8'hB1;
    queue_hood(h, 1'b0);
    for (int k = 0; k < 9; k++) begin
      h = '0;
      h.center_byte = 8'h99;
      h[8*k +: 8] = 8'hFF;
      queue_hood(h, 1'b0);
    end

    for (int k = 0; k < RANDOM_HOODS; k++) begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        for (int j = 0; j < 9; j++) begin
          h[8*j +: 8] = 8'($urandom_range(0, 255));
        end
      end else begin
        pct = (mode < 5) ? 15 : (mode < 8) ? 35 : 60;
        for (int j = 0; j < 9; j++) begin
          h[8*j +: 8] = seeded_byte(pct);
        end
      end
      queue_hood(h, k == 0 || $urandom_range(0, 199) == 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (hood_queue.size() != 0 || have_staged || in_valid || next_gen_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lacbu_pkg.sv
hdl/lacbu_next_gen.sv
hdl/life_aging_cell_byte_update.sv
tb/sv/life_aging_cell_byte_update_test.sv
